// ----- design/swadm_pkg.sv -----
// ----------------------------------------------------------------------------
// swadm_pkg
// Types, constants and tables shared by the six-wheel drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package swadm_pkg;

  localparam int PULSE_W    = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [10:0] PULSE_MIN = 11'd1000;
  localparam logic [10:0] PULSE_MAX = 11'd2000;
  localparam logic [10:0] STEER_LO  = 11'd1485;
  localparam logic [10:0] STEER_HI  = 11'd1515;
  localparam logic [11:0] DIR_HOLD  = 12'd1500;
  localparam logic [10:0] RADIUS_MAX = 11'd1400;

  localparam logic [9:0] RST_HALF_TRACK = 10'd271;
  localparam logic [9:0] RST_REAR_OFF   = 10'd278;
  localparam logic [9:0] RST_FRONT_OFF  = 10'd301;
  localparam logic [9:0] RST_MID_TRACK  = 10'd304;
  localparam logic [7:0] RST_TRIM_LF    = 8'd97;
  localparam logic [7:0] RST_TRIM_LB    = 8'd97;
  localparam logic [7:0] RST_TRIM_RF    = 8'd94;
  localparam logic [7:0] RST_TRIM_RB    = 8'd96;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_TRACK  = 4'd0,
    REG_REAR_OFF    = 4'd1,
    REG_FRONT_OFF   = 4'd2,
    REG_MID_TRACK   = 4'd3,
    REG_TRIM_LF     = 4'd4,
    REG_TRIM_LB     = 4'd5,
    REG_TRIM_RF     = 4'd6,
    REG_TRIM_RB     = 4'd7
  } swadm_reg_t;

  // atan(2^-i) in 2^-16 degree
  localparam logic [22:0] CORDIC_TAB [16] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117306,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115
  };

  typedef struct packed {
    logic [9:0] half_track;
    logic [9:0] rear_off;
    logic [9:0] front_off;
    logic [9:0] mid_track;
    logic [7:0] trim_lf;
    logic [7:0] trim_lb;
    logic [7:0] trim_rf;
    logic [7:0] trim_rb;
  } swadm_cfg_t;

  typedef struct packed {
    logic [6:0]  speed;
    logic [10:0] radius;
    logic        turn_right;
    logic        turn_left;
    logic        reverse;
    logic        update;
  } swadm_job_t;

endpackage

`default_nettype wire

// ----- design/swadm_ifs.sv -----
// ----------------------------------------------------------------------------
// swadm interfaces
// Frame, result and register-write channels of the drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

interface swadm_frame_if;
  import swadm_pkg::*;
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] throttle_pulse;
  logic [PULSE_W-1:0] steer_pulse;
  logic [PULSE_W-1:0] direction_pulse;
  modport source (output valid, throttle_pulse, steer_pulse, direction_pulse, input ready);
  modport sink   (input valid, throttle_pulse, steer_pulse, direction_pulse, output ready);
endinterface

interface swadm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_left_front;
  logic [7:0] duty_left_middle;
  logic [7:0] duty_left_back;
  logic [7:0] duty_right_front;
  logic [7:0] duty_right_middle;
  logic [7:0] duty_right_back;
  logic       drive_reverse;
  logic       motors_update;
  logic [7:0] servo_left_front;
  logic [7:0] servo_left_back;
  logic [7:0] servo_right_front;
  logic [7:0] servo_right_back;
  modport source (output valid, duty_left_front, duty_left_middle, duty_left_back,
                  duty_right_front, duty_right_middle, duty_right_back, drive_reverse,
                  motors_update, servo_left_front, servo_left_back, servo_right_front,
                  servo_right_back, input ready);
  modport sink   (input valid, duty_left_front, duty_left_middle, duty_left_back,
                  duty_right_front, duty_right_middle, duty_right_back, drive_reverse,
                  motors_update, servo_left_front, servo_left_back, servo_right_front,
                  servo_right_back, output ready);
endinterface

interface swadm_cfg_if;
  import swadm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/swadm_front.sv -----
// ----------------------------------------------------------------------------
// swadm_front
// Clamps the pulse widths, classifies the turn and derives speed and radius.
// ----------------------------------------------------------------------------
`default_nettype none

module swadm_front (
  swadm_frame_if.sink            frame,
  input  logic                   full,
  output logic                   push,
  output swadm_pkg::swadm_job_t  push_data
);
  import swadm_pkg::*;

  function automatic logic [10:0] clamp_pulse(input logic [PULSE_W-1:0] p);
    if (p < PULSE_W'(PULSE_MIN)) begin
      return PULSE_MIN;
    end else if (p > PULSE_W'(PULSE_MAX)) begin
      return PULSE_MAX;
    end
    return p[10:0];
  endfunction

  logic [10:0] thr_c;
  logic [10:0] st_c;
  logic [9:0]  thr_off;
  logic [22:0] speed_prod;
  logic        right;
  logic        left;
  logic [8:0]  steer_off;
  logic [16:0] steer_n;
  logic [34:0] radius_prod;

  assign frame.ready = !full;
  assign push        = frame.valid && !full;

  always_comb begin
    thr_c       = clamp_pulse(frame.throttle_pulse);
    st_c        = clamp_pulse(frame.steer_pulse);
    thr_off     = 10'(thr_c - PULSE_MIN);
    // divide by ten: exact for 0..1000
    speed_prod  = 23'(thr_off) * 23'd6554;
    right       = st_c > STEER_HI;
    left        = st_c < STEER_LO;
    if (right) begin
      steer_off = 9'(st_c - STEER_HI);
    end else if (left) begin
      steer_off = 9'(STEER_LO - st_c);
    end else begin
      steer_off = '0;
    end
    // off * 800 / 485 = off * 160 / 97, reciprocal exact over the range
    steer_n     = (17'(steer_off) << 7) + (17'(steer_off) << 5);
    radius_prod = 35'(steer_n) * 35'd172962;

    push_data.speed      = speed_prod[22:16];
    push_data.radius     = RADIUS_MAX - radius_prod[34:24];
    push_data.turn_right = right;
    push_data.turn_left  = left;
    push_data.reverse    = frame.direction_pulse < DIR_HOLD;
    push_data.update     = frame.direction_pulse != DIR_HOLD;
  end

endmodule

`default_nettype wire

// ----- design/swadm_queue.sv -----
// ----------------------------------------------------------------------------
// swadm_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module swadm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  swadm_pkg::swadm_job_t push_data,
  output logic                  full,
  input  logic                  pop,
  output swadm_pkg::swadm_job_t pop_data,
  output logic                  empty
);
  import swadm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  swadm_job_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/swadm_cordic.sv -----
// ----------------------------------------------------------------------------
// swadm_cordic
// Sixteen-step vectoring unit giving atan(a/b) in whole degrees, signed.
// ----------------------------------------------------------------------------
`default_nettype none

module swadm_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [9:0]         a,
  input  logic signed [12:0] b,
  output logic               busy,
  output logic signed [7:0]  theta
);
  import swadm_pkg::*;

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [24:0] z;
  logic [3:0]         iter;
  logic               b_neg;
  logic               b_zero;
  logic               a_nz;

  logic [12:0]        b_abs;
  logic signed [35:0] x_div;
  logic signed [35:0] y_sh;
  logic signed [35:0] y_div;
  logic [35:0]        low_mask;
  logic signed [24:0] tab;
  logic signed [24:0] z_rnd;
  logic [6:0]         mag;

  always_comb begin
    b_abs    = b[12] ? 13'(-b) : 13'(b);
    x_div    = x >>> iter;
    y_sh     = y >>> iter;
    low_mask = ~({36{1'b1}} << iter);
    // truncate towards zero
    y_div    = (y[35] && (|(36'(y) & low_mask))) ? y_sh + 36'sd1 : y_sh;
    tab      = signed'(25'(CORDIC_TAB[iter]));
    z_rnd    = z + 25'sd32768;
    mag      = z[24] ? 7'd0 : z_rnd[22:16];
    if (b_zero) begin
      theta = a_nz ? 8'sd90 : 8'sd0;
    end else if (b_neg) begin
      theta = -signed'({1'b0, mag});
    end else begin
      theta = signed'({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      iter   <= '0;
      x      <= signed'(36'(b_abs[11:0]) << 20);
      y      <= signed'(36'(a) << 20);
      z      <= '0;
      b_neg  <= b[12];
      b_zero <= b == '0;
      a_nz   <= a != '0;
    end else if (busy) begin
      if (y > 0) begin
        x <= x + y_div;
        y <= y - x_div;
        z <= z + tab;
      end else begin
        x <= x - y_div;
        y <= y + x_div;
        z <= z - tab;
      end
      iter <= iter + 1'b1;
      if (iter == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/swadm_back.sv -----
// ----------------------------------------------------------------------------
// swadm_back
// Wheel speed sequencer (shared multiplier, root and divider), four angle
// units and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swadm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  swadm_pkg::swadm_job_t job_in,
  output logic                  job_pop,
  input  swadm_pkg::swadm_cfg_t cfg_q,
  swadm_result_if.source        result
);
  import swadm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV1, S_DIV2, S_DONE} state_t;

  function automatic logic [7:0] to_duty(input logic [18:0] v);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = (15'(v[6:0]) << 8) - 15'(v[6:0]);
    prod   = 28'(scaled) * 28'd5243;
    if (v > 19'd100) begin
      return 8'd255;
    end
    return prod[26:19];
  endfunction

  function automatic logic [7:0] servo_sat(input logic [7:0] trim,
                                           input logic signed [7:0] delta);
    logic signed [9:0] sum;
    sum = signed'({2'b00, trim}) + 10'(delta);
    if (sum < 0) begin
      return 8'd0;
    end else if (sum > 10'sd180) begin
      return 8'd180;
    end
    return sum[7:0];
  endfunction

  state_t      state;
  swadm_job_t  job;
  logic [4:0]  step;
  logic [13:0] ss;
  logic [19:0] sqa;
  logic [20:0] sqb;
  logic [21:0] q;
  logic [37:0] sq_v;
  logic [37:0] sq_res;
  logic [37:0] sq_bit;
  logic [17:0] nmid;
  logic [12:0] rem;
  logic [12:0] divisor;
  logic [18:0] quot;
  logic [18:0] v2;
  logic [18:0] v3;

  logic               lane_start;
  logic [3:0]         lane_busy;
  logic signed [7:0]  th_a;
  logic signed [7:0]  th_b;
  logic signed [7:0]  th_c;
  logic signed [7:0]  th_d;
  logic signed [12:0] rp_in;
  logic signed [12:0] rm_in;

  logic signed [12:0] dq;
  logic [10:0]        dq_abs;
  logic signed [12:0] mid_diff;
  logic [11:0]        den;
  logic [21:0]        op_a;
  logic [15:0]        op_b;
  logic [37:0]        prod;
  logic [37:0]        sq_sum;
  logic               sq_ge;
  logic [37:0]        sq_res_next;
  logic [13:0]        trial;
  logic               div_ge;
  logic [13:0]        div_sub;
  logic [18:0]        quot_next;
  logic               out_free;
  logic               emit;
  logic               turning;
  logic [7:0]         p1;
  logic [7:0]         p2;
  logic [7:0]         p3;
  logic signed [7:0]  dl_lf;
  logic signed [7:0]  dl_lb;
  logic signed [7:0]  dl_rf;
  logic signed [7:0]  dl_rb;

  assign job_pop    = (state == S_IDLE) && job_valid;
  assign lane_start = job_pop && (job_in.turn_right || job_in.turn_left);
  assign rp_in      = signed'(13'(job_in.radius)) + signed'(13'(cfg_q.half_track));
  assign rm_in      = signed'(13'(job_in.radius)) - signed'(13'(cfg_q.half_track));

  swadm_cordic u_lane_a (.clk, .rst, .start(lane_start), .a(cfg_q.front_off), .b(rp_in),
                         .busy(lane_busy[0]), .theta(th_a));
  swadm_cordic u_lane_b (.clk, .rst, .start(lane_start), .a(cfg_q.rear_off), .b(rp_in),
                         .busy(lane_busy[1]), .theta(th_b));
  swadm_cordic u_lane_c (.clk, .rst, .start(lane_start), .a(cfg_q.front_off), .b(rm_in),
                         .busy(lane_busy[2]), .theta(th_c));
  swadm_cordic u_lane_d (.clk, .rst, .start(lane_start), .a(cfg_q.rear_off), .b(rm_in),
                         .busy(lane_busy[3]), .theta(th_d));

  always_comb begin
    dq       = signed'(13'(job.radius)) - signed'(13'(cfg_q.half_track));
    dq_abs   = dq[12] ? 11'(-dq) : 11'(dq);
    mid_diff = signed'(13'(job.radius)) - signed'(13'(cfg_q.mid_track));
    den      = 12'(job.radius) + 12'(cfg_q.mid_track);
    turning  = job.turn_right || job.turn_left;

    case (step)
      5'd0: begin
        op_a = 22'(job.speed);
        op_b = 16'(job.speed);
      end
      5'd1: begin
        op_a = 22'(cfg_q.front_off);
        op_b = 16'(cfg_q.front_off);
      end
      5'd2: begin
        op_a = 22'(dq_abs);
        op_b = 16'(dq_abs);
      end
      5'd4: begin
        op_a = q;
        op_b = {ss, 2'b00};
      end
      5'd5: begin
        op_a = (mid_diff > 0) ? 22'(mid_diff[10:0]) : 22'd0;
        op_b = 16'(job.speed);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = 38'(op_a) * 38'(op_b);

    sq_sum      = sq_res + sq_bit;
    sq_ge       = sq_v >= sq_sum;
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

    trial     = {rem, quot[18]};
    div_ge    = trial >= {1'b0, divisor};
    div_sub   = trial - {1'b0, divisor};
    quot_next = {quot[17:0], div_ge};

    out_free = !result.valid || result.ready;
    emit     = (state == S_DONE) && out_free && (lane_busy == '0);

    p1 = to_duty(19'(job.speed));
    p2 = to_duty(v2);
    p3 = to_duty(v3);

    if (job.turn_right) begin
      dl_lf = th_a;
      dl_lb = -th_b;
      dl_rf = th_c;
      dl_rb = -th_d;
    end else if (job.turn_left) begin
      dl_lf = -th_c;
      dl_lb = th_d;
      dl_rf = -th_a;
      dl_rb = th_b;
    end else begin
      dl_lf = '0;
      dl_lb = '0;
      dl_rf = '0;
      dl_rb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            step  <= '0;
            state <= (job_in.turn_right || job_in.turn_left) ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          case (step)
            5'd0: ss   <= prod[13:0];
            5'd1: sqa  <= prod[19:0];
            5'd2: sqb  <= prod[20:0];
            5'd3: q    <= 22'(sqa) + 22'(sqb);
            5'd4: sq_v <= prod;
            default: nmid <= prod[17:0];
          endcase
          step <= step + 1'b1;
          if (step == 5'd5) begin
            sq_res <= '0;
            sq_bit <= 38'd1 << 36;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v <= sq_v - sq_sum;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            rem     <= '0;
            divisor <= {1'b0, den};
            quot    <= sq_res_next[18:0];
            step    <= '0;
            state   <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (step == 5'd18) begin
            v2      <= 19'((20'(quot_next) + 20'd1) >> 1);
            rem     <= '0;
            divisor <= {den, 1'b0};
            quot    <= 19'({nmid, 1'b0}) + 19'(den);
            step    <= '0;
            state   <= S_DIV2;
          end else begin
            rem  <= div_ge ? div_sub[12:0] : trial[12:0];
            quot <= quot_next;
            step <= step + 1'b1;
          end
        end
        S_DIV2: begin
          rem  <= div_ge ? div_sub[12:0] : trial[12:0];
          quot <= quot_next;
          step <= step + 1'b1;
          if (step == 5'd18) begin
            v3    <= quot_next;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            result.duty_left_front   <= job.turn_left ? p2 : p1;
            result.duty_left_middle  <= job.turn_left ? p3 : p1;
            result.duty_left_back    <= job.turn_left ? p2 : p1;
            result.duty_right_front  <= job.turn_right ? p2 : p1;
            result.duty_right_middle <= job.turn_right ? p3 : p1;
            result.duty_right_back   <= job.turn_right ? p2 : p1;
            result.drive_reverse     <= job.reverse;
            result.motors_update     <= job.update;
            result.servo_left_front  <= servo_sat(cfg_q.trim_lf, turning ? dl_lf : 8'sd0);
            result.servo_left_back   <= servo_sat(cfg_q.trim_lb, turning ? dl_lb : 8'sd0);
            result.servo_right_front <= servo_sat(cfg_q.trim_rf, turning ? dl_rf : 8'sd0);
            result.servo_right_back  <= servo_sat(cfg_q.trim_rb, turning ? dl_rb : 8'sd0);
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/six_wheel_ackermann_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// six_wheel_ackermann_drive_mixer
// Radio frame to six motor duties and four steering servo angles.
// ----------------------------------------------------------------------------
// A frame is taken whenever the job queue has room, one per cycle, and
// produces exactly one result. A straight-ahead frame goes from the idle
// state straight to the done state; a turning frame passes through the
// shared multiplier (6 steps), the bit-serial square root and two passes of
// the radix-2 divider, while the four angle units run alongside. The back
// end starts the next job while a finished result still waits in the output
// register. Register writes are taken every cycle; indexes above 7 are
// ignored.
`default_nettype none

module six_wheel_ackermann_drive_mixer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  swadm_cfg_if.sink      cfg,
  swadm_frame_if.sink    frame,
  swadm_result_if.source result
);
  import swadm_pkg::*;

  swadm_cfg_t cfg_q;
  swadm_job_t push_data;
  swadm_job_t pop_data;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.half_track <= RST_HALF_TRACK;
      cfg_q.rear_off   <= RST_REAR_OFF;
      cfg_q.front_off  <= RST_FRONT_OFF;
      cfg_q.mid_track  <= RST_MID_TRACK;
      cfg_q.trim_lf    <= RST_TRIM_LF;
      cfg_q.trim_lb    <= RST_TRIM_LB;
      cfg_q.trim_rf    <= RST_TRIM_RF;
      cfg_q.trim_rb    <= RST_TRIM_RB;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HALF_TRACK: cfg_q.half_track <= cfg.data;
        REG_REAR_OFF:   cfg_q.rear_off   <= cfg.data;
        REG_FRONT_OFF:  cfg_q.front_off  <= cfg.data;
        REG_MID_TRACK:  cfg_q.mid_track  <= cfg.data;
        REG_TRIM_LF:    cfg_q.trim_lf    <= cfg.data[7:0];
        REG_TRIM_LB:    cfg_q.trim_lb    <= cfg.data[7:0];
        REG_TRIM_RF:    cfg_q.trim_rf    <= cfg.data[7:0];
        REG_TRIM_RB:    cfg_q.trim_rb    <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  swadm_front u_front (
    .frame     (frame),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  swadm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  swadm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!empty),
    .job_in    (pop_data),
    .job_pop   (pop),
    .cfg_q     (cfg_q),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- design/swadm_checker.sv -----
// ----------------------------------------------------------------------------
// swadm_checker
// Port-level checks on the result channel of the drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module swadm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] duty_lf,
  input logic [7:0] duty_rf,
  input logic       drive_reverse,
  input logic       motors_update,
  input logic [7:0] servo_lf,
  input logic [7:0] servo_lb,
  input logic [7:0] servo_rf,
  input logic [7:0] servo_rb
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty_lf) && $stable(duty_rf)
      && $stable(servo_lf) && $stable(servo_rb))
    else $error("stalled result changed");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> servo_lf <= 8'd180 && servo_lb <= 8'd180
      && servo_rf <= 8'd180 && servo_rb <= 8'd180)
    else $error("servo angle out of range");

  a_hold_forward: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motors_update |-> !drive_reverse)
    else $error("reverse flagged on hold");

endmodule

bind six_wheel_ackermann_drive_mixer swadm_checker u_swadm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .duty_lf       (result.duty_left_front),
  .duty_rf       (result.duty_right_front),
  .drive_reverse (result.drive_reverse),
  .motors_update (result.motors_update),
  .servo_lf      (result.servo_left_front),
  .servo_lb      (result.servo_left_back),
  .servo_rf      (result.servo_right_front),
  .servo_rb      (result.servo_right_back)
);

`default_nettype wire

// ----- tb/six_wheel_ackermann_drive_mixer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_wheel_ackermann_drive_mixer_test
// Drives radio frames and register writes into the drive mixer under random
// gaps and back-pressure. A scoreboard predicts the duties, direction flags
// and servo angles of each frame and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module six_wheel_ackermann_drive_mixer_test;
  import swadm_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 75;

  typedef struct {
    logic [7:0] duty_lf, duty_lm, duty_lb, duty_rf, duty_rm, duty_rb;
    logic       reverse, update;
    logic [7:0] servo_lf, servo_lb, servo_rf, servo_rb;
  } mixer_out_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   results_seen;
  int   idle_cycles;

  swadm_cfg_if    cfg_ch ();
  swadm_frame_if  frame_ch ();
  swadm_result_if result_ch ();

  six_wheel_ackermann_drive_mixer i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .frame  (frame_ch),
    .result (result_ch)
  );

  class mixer_scoreboard;
    swadm_cfg_t regs;
    mixer_out_t expected_q[$];
    int         errors;

    function new();
      regs = '{half_track: RST_HALF_TRACK, rear_off: RST_REAR_OFF,
               front_off: RST_FRONT_OFF, mid_track: RST_MID_TRACK,
               trim_lf: RST_TRIM_LF, trim_lb: RST_TRIM_LB,
               trim_rf: RST_TRIM_RF, trim_rb: RST_TRIM_RB};
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HALF_TRACK: regs.half_track = data;
        REG_REAR_OFF:   regs.rear_off   = data;
        REG_FRONT_OFF:  regs.front_off  = data;
        REG_MID_TRACK:  regs.mid_track  = data;
        REG_TRIM_LF:    regs.trim_lf    = data[7:0];
        REG_TRIM_LB:    regs.trim_lb    = data[7:0];
        REG_TRIM_RF:    regs.trim_rf    = data[7:0];
        REG_TRIM_RB:    regs.trim_rb    = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_pulse(logic [11:0] p);
      if (p < 1000) return 1000;
      if (p > 2000) return 2000;
      return p;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // vectoring CORDIC, b > 0, result in whole degrees
    function int atan_deg(int unsigned a, int unsigned b);
      longint x, y, z, nx, dv;
      x = longint'(b) <<< 20;
      y = longint'(a) <<< 20;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        dv = longint'(1) <<< i;
        if (y > 0) begin
          nx = x + y / dv;
          y  = y - x / dv;
          z += longint'(CORDIC_TAB[i]);
        end else begin
          nx = x - y / dv;
          y  = y + x / dv;
          z -= longint'(CORDIC_TAB[i]);
        end
        x = nx;
      end
      if (z < 0) return 0;
      return int'((z + 32768) >>> 16);
    endfunction

    function int steer_angle(int unsigned a, int b);
      if (b > 0) return atan_deg(a, b);
      if (b < 0) return -atan_deg(a, -b);
      return (a > 0) ? 90 : 0;
    endfunction

    function logic [7:0] to_duty(longint unsigned v);
      longint unsigned d;
      d = v * 255 / 100;
      return (d > 255) ? 8'd255 : d[7:0];
    endfunction

    function logic [7:0] servo_sum(logic [7:0] trim, int delta);
      int v;
      v = int'(trim) + delta;
      if (v < 0) v = 0;
      if (v > 180) v = 180;
      return v[7:0];
    endfunction

    function void note_frame(logic [11:0] thr_p, logic [11:0] st_p, logic [11:0] dir_p);
      int unsigned thr, st, dir;
      longint unsigned spd, q, den, v2, v3;
      longint dq;
      int r, d1, d4;
      int unsigned d2, d3;
      bit right, left;
      logic [7:0] p1, p2, p3;
      mixer_out_t e;
      thr = clamp_pulse(thr_p);
      st  = clamp_pulse(st_p);
      dir = clamp_pulse(dir_p);
      spd = (thr - 1000) * 100 / 1000;
      d1 = regs.half_track; d2 = regs.rear_off;
      d3 = regs.front_off;  d4 = regs.mid_track;
      right = st > 1515;
      left  = st < 1485;
      r = 1400;
      if (right) r = 1400 - int'((st - 1515) * 800 / 485);
      if (left)  r = 1400 - int'((1485 - st) * 800 / 485);
      p1 = to_duty(spd);
      p2 = 0; p3 = 0;
      if (right || left) begin
        dq  = r - d1;
        q   = longint'(d3) * d3 + dq * dq;
        den = r + d4;
        v2  = (sqrt_floor(4 * spd * spd * q) / den + 1) / 2;
        v3  = 0;
        if (r > d4) v3 = (2 * spd * (r - d4) + den) / (2 * den);
        p2 = to_duty(v2);
        p3 = to_duty(v3);
      end
      if (right) begin
        e.duty_lf = p1; e.duty_lm = p1; e.duty_lb = p1;
        e.duty_rf = p2; e.duty_rm = p3; e.duty_rb = p2;
        e.servo_lf = servo_sum(regs.trim_lf, steer_angle(d3, r + d1));
        e.servo_lb = servo_sum(regs.trim_lb, -steer_angle(d2, r + d1));
        e.servo_rf = servo_sum(regs.trim_rf, steer_angle(d3, r - d1));
        e.servo_rb = servo_sum(regs.trim_rb, -steer_angle(d2, r - d1));
      end else if (left) begin
        e.duty_lf = p2; e.duty_lm = p3; e.duty_lb = p2;
        e.duty_rf = p1; e.duty_rm = p1; e.duty_rb = p1;
        e.servo_lf = servo_sum(regs.trim_lf, -steer_angle(d3, r - d1));
        e.servo_lb = servo_sum(regs.trim_lb, steer_angle(d2, r - d1));
        e.servo_rf = servo_sum(regs.trim_rf, -steer_angle(d3, r + d1));
        e.servo_rb = servo_sum(regs.trim_rb, steer_angle(d2, r + d1));
      end else begin
        e.duty_lf = p1; e.duty_lm = p1; e.duty_lb = p1;
        e.duty_rf = p1; e.duty_rm = p1; e.duty_rb = p1;
        e.servo_lf = servo_sum(regs.trim_lf, 0);
        e.servo_lb = servo_sum(regs.trim_lb, 0);
        e.servo_rf = servo_sum(regs.trim_rf, 0);
        e.servo_rb = servo_sum(regs.trim_rb, 0);
      end
      e.reverse = dir < 1500;
      e.update  = dir != 1500;
      expected_q.push_back(e);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task field(string what, int got, int want);
      if (got != want) report(what, got, want);
    endtask

    task check_result(mixer_out_t g);
      mixer_out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = expected_q.pop_front();
      field("duty_left_front", g.duty_lf, e.duty_lf);
      field("duty_left_middle", g.duty_lm, e.duty_lm);
      field("duty_left_back", g.duty_lb, e.duty_lb);
      field("duty_right_front", g.duty_rf, e.duty_rf);
      field("duty_right_middle", g.duty_rm, e.duty_rm);
      field("duty_right_back", g.duty_rb, e.duty_rb);
      field("drive_reverse", g.reverse, e.reverse);
      field("motors_update", g.update, e.update);
      field("servo_left_front", g.servo_lf, e.servo_lf);
      field("servo_left_back", g.servo_lb, e.servo_lb);
      field("servo_right_front", g.servo_rf, e.servo_rf);
      field("servo_right_back", g.servo_rb, e.servo_rb);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  mixer_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    mixer_out_t g;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (frame_ch.valid && frame_ch.ready)
        sb.note_frame(frame_ch.throttle_pulse, frame_ch.steer_pulse,
                      frame_ch.direction_pulse);
      if (result_ch.valid && result_ch.ready) begin
        g.duty_lf  = result_ch.duty_left_front;
        g.duty_lm  = result_ch.duty_left_middle;
        g.duty_lb  = result_ch.duty_left_back;
        g.duty_rf  = result_ch.duty_right_front;
        g.duty_rm  = result_ch.duty_right_middle;
        g.duty_rb  = result_ch.duty_right_back;
        g.reverse  = result_ch.drive_reverse;
        g.update   = result_ch.motors_update;
        g.servo_lf = result_ch.servo_left_front;
        g.servo_lb = result_ch.servo_left_back;
        g.servo_rf = result_ch.servo_right_front;
        g.servo_rb = result_ch.servo_right_back;
        sb.check_result(g);
        results_seen++;
      end
      if ((cfg_ch.valid && cfg_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
          (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure, with one long hold-off once traffic is flowing
  initial begin
    bit held;
    int r;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (r < 8) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(negedge clk);
      end else if (r < 55) begin
        result_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  bit no_gaps;

  task send_frame(logic [11:0] thr, logic [11:0] st, logic [11:0] dir);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_ch.throttle_pulse  <= thr;
    frame_ch.steer_pulse     <= st;
    frame_ch.direction_pulse <= dir;
    frame_ch.valid           <= 1'b1;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task drain();
    frame_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task set_geometry(int d1, int d2, int d3, int d4, int lf, int lb, int rf, int rb);
    drain();
    write_reg(REG_HALF_TRACK, d1);
    write_reg(REG_REAR_OFF, d2);
    write_reg(REG_FRONT_OFF, d3);
    write_reg(REG_MID_TRACK, d4);
    write_reg(REG_TRIM_LF, lf);
    write_reg(REG_TRIM_LB, lb);
    write_reg(REG_TRIM_RF, rf);
    write_reg(REG_TRIM_RB, rb);
  endtask

  function automatic logic [11:0] rand_steer();
    int r;
    logic [11:0] edges[4] = '{12'd1484, 12'd1485, 12'd1515, 12'd1516};
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(1485, 1515);
    if (r < 35) return edges[$urandom_range(0, 3)];
    if (r < 80) return $urandom_range(1000, 2000);
    return $urandom_range(0, 4095);
  endfunction

  function logic [11:0] rand_pulse();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1000, 2000)
                                        : $urandom_range(0, 4095);
  endfunction

  function logic [11:0] rand_dir();
    return ($urandom_range(0, 99) < 20) ? 12'(DIR_HOLD) : rand_pulse();
  endfunction

  function int rand_dim();
    return ($urandom_range(0, 99) < 70) ? $urandom_range(1, 599)
                                        : $urandom_range(0, 1023);
  endfunction

  function int rand_trim();
    return {$urandom_range(0, 3), 8'($urandom_range(0, 180))};
  endfunction

  initial begin
    sb = new();
    mismatches   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    rst = 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    frame_ch.valid           <= 1'b0;
    frame_ch.throttle_pulse  <= '0;
    frame_ch.steer_pulse     <= '0;
    frame_ch.direction_pulse <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry: clamps, band edges, hold, reverse
    send_frame(12'd0, 12'd0, 12'd0);
    send_frame(12'd4095, 12'd4095, 12'd4095);
    send_frame(12'd2000, 12'd1484, 12'd1499);
    send_frame(12'd2000, 12'd1485, 12'd1500);
    send_frame(12'd2000, 12'd1515, 12'd1501);
    send_frame(12'd2000, 12'd1516, 12'd2000);
    send_frame(12'd1500, 12'd1000, 12'd1000);
    send_frame(12'd1000, 12'd2000, 12'd1500);
    send_frame(12'd1999, 12'd1500, 12'd2048);
    send_frame(12'd2730, 12'd2730, 12'd1365);

    // zero angle denominator and zero front offset
    set_geometry(1000, 0, 0, 0, 0, 180, 0, 180);
    send_frame(12'd2000, 12'd1758, 12'd1600);
    send_frame(12'd2000, 12'd1242, 12'd1400);
    drain();
    write_reg(REG_FRONT_OFF, 599);
    send_frame(12'd2000, 12'd1758, 12'd1600);
    send_frame(12'd2000, 12'd1242, 12'd1600);

    // negative denominator, middle wheels past the radius, trim saturation
    set_geometry(1023, 1023, 1023, 1023, 180, 0, 180, 0);
    send_frame(12'd2000, 12'd2000, 12'd1600);
    send_frame(12'd2000, 12'd0, 12'd1400);
    send_frame(12'd1700, 12'd1800, 12'd1500);
    send_frame(12'd1300, 12'd1100, 12'd1600);
    drain();
    write_reg(4'd9, 10'h3FF);
    write_reg(4'd15, 10'h155);
    send_frame(12'd2000, 12'd1600, 12'd1600);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_geometry(rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                   rand_trim(), rand_trim(), rand_trim(), rand_trim());
      if ($urandom_range(0, 3) == 0) write_reg($urandom_range(8, 15), $urandom_range(0, 1023));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (ph == 2 && n == PHASE_ITEMS / 2) drain();
        send_frame(rand_pulse(), rand_steer(), rand_dir());
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (150) @(negedge clk);
    mismatches = sb.errors;
    if (mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/swadm_pkg.sv
design/swadm_ifs.sv
design/swadm_front.sv
design/swadm_queue.sv
design/swadm_cordic.sv
design/swadm_back.sv
design/six_wheel_ackermann_drive_mixer.sv
design/swadm_checker.sv
tb/six_wheel_ackermann_drive_mixer_test.sv
